@@ hdl/cubic_bezier_subdivide_unit_macros.svh @@
// ----------------------------------------------------------------------------
// cubic_bezier_subdivide_unit_macros.svh
// Assertion macros for the cubic Bezier subdivision unit.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_SUBDIVIDE_UNIT_MACROS_SVH
`define CUBIC_BEZIER_SUBDIVIDE_UNIT_MACROS_SVH

`ifndef SYNTH
`define CBS_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define CBS_ASSERT(label, prop) `CBS_ASSERT_CLK(label, clock, reset, prop)
`else
`define CBS_ASSERT_CLK(label, clk, rst, prop)
`define CBS_ASSERT(label, prop)
`endif

`endif

@@ hdl/cbs_pkg.sv @@
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants of the cubic Bezier subdivision unit.
// ----------------------------------------------------------------------------
package cbs_pkg;

   localparam int NUM_PTS   = 10;
   localparam int IDX_W     = 4;
   localparam int NUM_LANES = 6;
   localparam int MID_LANES = 4;

   localparam logic [IDX_W-1:0] LAST_IDX_SINGLE = 4'd6;
   localparam logic [IDX_W-1:0] LAST_IDX_DOUBLE = 4'd9;
   localparam logic [1:0]       PHASE_LAST      = 2'd2;

   typedef enum logic {
      CMD_SINGLE = 1'b0,
      CMD_DOUBLE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_RUN,
      ENG_HOLD
   } eng_state_type;

   typedef enum logic [1:0] {
      PASS_EDGE,
      PASS_MID,
      PASS_TOP
   } pass_type;

   typedef struct packed {
      logic done;
      logic dbl;
   } eng_stat_type;

endpackage

@@ hdl/cbs_front.sv @@
// ----------------------------------------------------------------------------
// cbs_front
// Input register stage: decodes the mode and saturates both split parameters.
// ----------------------------------------------------------------------------
module cbs_front #(
   parameter int CW = 32,
   parameter int T  = 16,
   localparam int IN_BITS = 8*CW + 2*(T+1),
   localparam int IW      = IN_BITS + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic               in_cmd,
   input  logic [IN_BITS-1:0] in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [IW-1:0]      out_data
);
   import cbs_pkg::*;

   localparam logic [T:0] T_ONE = {1'b1, {T{1'b0}}};

   logic          valid_ff, valid_in;
   logic [IW-1:0] item_ff, item_in;
   logic [T:0]    t0_raw, t1_raw, t0_sat, t1_sat;
   logic          dbl;
   logic          accept;

   always_comb begin
      t0_raw  = in_data[8*CW +: T+1];
      t1_raw  = in_data[8*CW+T+1 +: T+1];
      t0_sat  = t0_raw[T] ? T_ONE : t0_raw;
      t1_sat  = t1_raw[T] ? T_ONE : t1_raw;
      dbl     = (cmd_type'(in_cmd) == CMD_DOUBLE);
      item_in = {dbl, t1_sat, t0_sat, in_data[8*CW-1:0]};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hdl/cbs_queue.sv @@
// ----------------------------------------------------------------------------
// cbs_queue
// Short first-in first-out queue between the front stage and the engine.
// ----------------------------------------------------------------------------
module cbs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_pop,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != CNT_W'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ hdl/cbs_lerp.sv @@
// ----------------------------------------------------------------------------
// cbs_lerp
// One coordinate lerp a + floor((b - a) * t / 2^T), two register stages.
// ----------------------------------------------------------------------------
module cbs_lerp #(
   parameter int CW = 32,
   parameter int T  = 16
) (
   input  logic                 clock,
   input  logic signed [CW-1:0] a,
   input  logic signed [CW-1:0] b,
   input  logic        [T:0]    t,
   output logic signed [CW-1:0] r
);
   localparam int PW = CW + T + 3;

   logic signed [CW:0]   d_ff, d_in;
   logic signed [CW-1:0] a1_ff, a2_ff;
   logic        [T:0]    t1_ff;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [PW-1:0] sum;

   assign d_in = {b[CW-1], b} - {a[CW-1], a};

   assign prod_in = $signed({{(T+2){d_ff[CW]}}, d_ff}) *
                    $signed({{(CW+2){1'b0}}, t1_ff});

   // product >>> T is the exact floor; the sum lies between a and b
   assign sum = (prod_ff >>> T) + $signed({{(PW-CW){a2_ff[CW-1]}}, a2_ff});
   assign r   = sum[CW-1:0];

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      a1_ff   <= a;
      t1_ff   <= t;
      prod_ff <= prod_in;
      a2_ff   <= a1_ff;
   end

endmodule

@@ hdl/cbs_engine.sv @@
// ----------------------------------------------------------------------------
// cbs_engine
// De Casteljau engine: six point lanes run three passes per curve.
// ----------------------------------------------------------------------------
module cbs_engine #(
   parameter int CW = 32,
   parameter int T  = 16,
   localparam int IW = 8*CW + 2*(T+1) + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  logic [IW-1:0]             q_data,
   output logic                      q_pop,
   input  logic                      take,
   output cbs_pkg::eng_stat_type     stat,
   output logic [2*CW-1:0]           pts [cbs_pkg::NUM_PTS]
);
   import cbs_pkg::*;

   eng_state_type state_ff, state_in;
   pass_type      pass_ff, pass_in;
   logic [1:0]    phase_ff, phase_in;

   logic [2*CW-1:0] p_ff   [4];
   logic [T:0]      t0_ff, t1_ff;
   logic            dbl_ff;
   logic [2*CW-1:0] lv1_ff [NUM_LANES];
   logic [2*CW-1:0] lv2_ff [MID_LANES];
   logic [2*CW-1:0] lv3_ff [MID_LANES];

   logic [2*CW-1:0] lane_a [NUM_LANES];
   logic [2*CW-1:0] lane_b [NUM_LANES];
   logic [T:0]      lane_t [NUM_LANES];
   logic [2*CW-1:0] lane_r [NUM_LANES];

   logic run_end, capture;

   assign run_end = (phase_ff == PHASE_LAST) && (pass_ff == PASS_TOP);
   assign capture = (state_ff == ENG_RUN) && (phase_ff == PHASE_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (q_valid) state_in = ENG_RUN;
         end
         ENG_RUN: begin
            if (run_end) state_in = ENG_HOLD;
         end
         ENG_HOLD: begin
            if (take) state_in = q_valid ? ENG_RUN : ENG_IDLE;
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = 1'b0;
      stat.done = 1'b0;
      stat.dbl  = dbl_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            q_pop = q_valid;
         end
         ENG_RUN: begin
            q_pop = 1'b0;
         end
         ENG_HOLD: begin
            stat.done = 1'b1;
            q_pop     = take && q_valid;
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      pass_in  = pass_ff;
      if (q_pop) begin
         phase_in = '0;
         pass_in  = PASS_EDGE;
      end else if (state_ff == ENG_RUN) begin
         if (phase_ff == PHASE_LAST) begin
            phase_in = '0;
            pass_in  = (pass_ff == PASS_EDGE) ? PASS_MID : PASS_TOP;
         end else begin
            phase_in = phase_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         pass_ff  <= PASS_EDGE;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         phase_ff <= phase_in;
      end
   end

   // lane operands: edges, then ab/bc/cd pairs, then abc/bcd pairs
   always_comb begin
      lane_a[0] = p_ff[0]; lane_b[0] = p_ff[1]; lane_t[0] = t0_ff;
      lane_a[1] = p_ff[1]; lane_b[1] = p_ff[2]; lane_t[1] = t0_ff;
      lane_a[2] = p_ff[2]; lane_b[2] = p_ff[3]; lane_t[2] = t0_ff;
      lane_a[3] = p_ff[0]; lane_b[3] = p_ff[1]; lane_t[3] = t1_ff;
      lane_a[4] = p_ff[1]; lane_b[4] = p_ff[2]; lane_t[4] = t1_ff;
      lane_a[5] = p_ff[2]; lane_b[5] = p_ff[3]; lane_t[5] = t1_ff;
      unique case (pass_ff)
         PASS_EDGE: begin
         end
         PASS_MID: begin
            lane_a[0] = lv1_ff[0]; lane_b[0] = lv1_ff[1]; lane_t[0] = t0_ff;
            lane_a[1] = lv1_ff[1]; lane_b[1] = lv1_ff[2]; lane_t[1] = t0_ff;
            lane_a[2] = lv1_ff[3]; lane_b[2] = lv1_ff[4]; lane_t[2] = t1_ff;
            lane_a[3] = lv1_ff[4]; lane_b[3] = lv1_ff[5]; lane_t[3] = t1_ff;
         end
         PASS_TOP: begin
            lane_a[0] = lv2_ff[0]; lane_b[0] = lv2_ff[1]; lane_t[0] = t0_ff;
            lane_a[1] = lv2_ff[0]; lane_b[1] = lv2_ff[1]; lane_t[1] = t1_ff;
            lane_a[2] = lv2_ff[2]; lane_b[2] = lv2_ff[3]; lane_t[2] = t0_ff;
            lane_a[3] = lv2_ff[2]; lane_b[3] = lv2_ff[3]; lane_t[3] = t1_ff;
         end
         default: begin
         end
      endcase
   end

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      cbs_lerp #(.CW(CW), .T(T)) u_lerp_x (
         .clock (clock),
         .a     (lane_a[k][CW-1:0]),
         .b     (lane_b[k][CW-1:0]),
         .t     (lane_t[k]),
         .r     (lane_r[k][CW-1:0])
      );
      cbs_lerp #(.CW(CW), .T(T)) u_lerp_y (
         .clock (clock),
         .a     (lane_a[k][2*CW-1:CW]),
         .b     (lane_b[k][2*CW-1:CW]),
         .t     (lane_t[k]),
         .r     (lane_r[k][2*CW-1:CW])
      );
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         p_ff[0] <= q_data[0*2*CW +: 2*CW];
         p_ff[1] <= q_data[1*2*CW +: 2*CW];
         p_ff[2] <= q_data[2*2*CW +: 2*CW];
         p_ff[3] <= q_data[3*2*CW +: 2*CW];
         t0_ff   <= q_data[8*CW +: T+1];
         t1_ff   <= q_data[8*CW+T+1 +: T+1];
         dbl_ff  <= q_data[IW-1];
      end
      if (capture) begin
         unique case (pass_ff)
            PASS_EDGE: begin
               for (int k = 0; k < NUM_LANES; k++) lv1_ff[k] <= lane_r[k];
            end
            PASS_MID: begin
               for (int k = 0; k < MID_LANES; k++) lv2_ff[k] <= lane_r[k];
            end
            PASS_TOP: begin
               for (int k = 0; k < MID_LANES; k++) lv3_ff[k] <= lane_r[k];
            end
            default: begin
            end
         endcase
      end
   end

   // point list in emission order
   always_comb begin
      pts[0] = p_ff[0];
      pts[1] = lv1_ff[0];
      pts[2] = lv2_ff[0];
      pts[3] = lv3_ff[0];
      if (dbl_ff) begin
         pts[4] = lv3_ff[1];
         pts[5] = lv3_ff[2];
         pts[6] = lv3_ff[3];
         pts[7] = lv2_ff[3];
         pts[8] = lv1_ff[5];
         pts[9] = p_ff[3];
      end else begin
         pts[4] = lv2_ff[1];
         pts[5] = lv1_ff[2];
         pts[6] = p_ff[3];
         pts[7] = p_ff[3];
         pts[8] = p_ff[3];
         pts[9] = p_ff[3];
      end
   end

endmodule

@@ hdl/cbs_emit.sv @@
// ----------------------------------------------------------------------------
// cbs_emit
// Result buffer: holds one finished point list and sends a point per transfer.
// ----------------------------------------------------------------------------
module cbs_emit #(
   parameter int CW = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cbs_pkg::eng_stat_type       stat,
   input  logic [2*CW-1:0]             pts [cbs_pkg::NUM_PTS],
   output logic                        take,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [CW-1:0]               rsp_x,
   output logic [CW-1:0]               rsp_y,
   output logic [cbs_pkg::IDX_W-1:0]   rsp_idx,
   output logic                        rsp_last
);
   import cbs_pkg::*;

   logic [2*CW-1:0]  buf_ff [NUM_PTS];
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] lastidx_ff, lastidx_in;
   logic             last_now, xfer;

   assign last_now  = (idx_ff == lastidx_ff);
   assign xfer      = busy_ff && rsp_ready;
   assign take      = stat.done && (!busy_ff || (xfer && last_now));

   assign rsp_valid = busy_ff;
   assign rsp_x     = buf_ff[idx_ff][CW-1:0];
   assign rsp_y     = buf_ff[idx_ff][2*CW-1:CW];
   assign rsp_idx   = idx_ff;
   assign rsp_last  = last_now;

   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      lastidx_in = lastidx_ff;
      if (take) begin
         busy_in    = 1'b1;
         idx_in     = '0;
         lastidx_in = stat.dbl ? LAST_IDX_DOUBLE : LAST_IDX_SINGLE;
      end else if (xfer) begin
         if (last_now) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         idx_ff     <= '0;
         lastidx_ff <= LAST_IDX_SINGLE;
      end else begin
         busy_ff    <= busy_in;
         idx_ff     <= idx_in;
         lastidx_ff <= lastidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int k = 0; k < NUM_PTS; k++) buf_ff[k] <= pts[k];
      end
   end

endmodule

@@ hdl/cubic_bezier_subdivide_unit.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_subdivide_unit
// Fixed-point de Casteljau subdivision of a 2D cubic Bezier at one or two t.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one curve per transfer: P0..P3, t_first, t_second,
//   with the split mode (single or double) on req_tuser.
//   rsp channel returns the subdivision points one per transfer, 7 for a
//   single split and 10 for a double split, rsp_tlast on the final point.
//   The first point of an isolated curve passes the input register, the
//   queue, the engine run and the handoff to the result buffer.
//   The engine takes a new curve only after handing off the last; the curve
//   rate is set by its three passes over its six shared lerp lanes plus the
//   handoff, and by the 10-point drain of a double split on the result channel.
//   A two-entry queue sits between the input register and the engine, and
//   the result buffer frees the engine, so a new curve is taken while the
//   previous one is still being sent.
//   Reset clears all control state; no curve is in flight afterwards.
//   When rsp_tready is low, the current point holds and the engine stops
//   after one finished curve; input then backs up into the queue.
// ----------------------------------------------------------------------------
`include "cubic_bezier_subdivide_unit_macros.svh"

module cubic_bezier_subdivide_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int T_FRAC_BITS = 16,
   localparam int IN_BITS = 8*COORD_WIDTH + 2*(T_FRAC_BITS+1),
   localparam int REQ_W   = ((IN_BITS + 7) / 8) * 8,
   localparam int RSP_W   = ((2*COORD_WIDTH + cbs_pkg::IDX_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y, t_first, t_second
   input  logic [REQ_W-1:0] req_tdata,
   // cmd
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // point_x, point_y, point_index
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);
   import cbs_pkg::*;

   localparam int IW = IN_BITS + 1;

   logic                     f_valid, f_ready;
   logic [IW-1:0]            f_data;
   logic                     q_valid, q_pop;
   logic [IW-1:0]            q_data;
   logic                     take;
   eng_stat_type             stat;
   logic [2*COORD_WIDTH-1:0] pts [NUM_PTS];
   logic [COORD_WIDTH-1:0]   rsp_x, rsp_y;
   logic [IDX_W-1:0]         rsp_idx;

   cbs_front #(.CW(COORD_WIDTH), .T(T_FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_data   (req_tdata[IN_BITS-1:0]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   cbs_queue #(.WIDTH(IW), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_data  (q_data)
   );

   cbs_engine #(.CW(COORD_WIDTH), .T(T_FRAC_BITS)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .take    (take),
      .stat    (stat),
      .pts     (pts)
   );

   cbs_emit #(.CW(COORD_WIDTH)) u_emit (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .pts       (pts),
      .take      (take),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_x     (rsp_x),
      .rsp_y     (rsp_y),
      .rsp_idx   (rsp_idx),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({rsp_idx, rsp_y, rsp_x});

   `CBS_ASSERT(a_pop_needs_entry, q_pop |-> q_valid)
   `CBS_ASSERT(a_take_starts_list, take |=> rsp_tvalid && (rsp_idx == '0))
   `CBS_ASSERT(a_last_at_end, rsp_tvalid && rsp_tlast |-> (rsp_idx == LAST_IDX_SINGLE) || (rsp_idx == LAST_IDX_DOUBLE))
   `CBS_ASSERT(a_index_steps, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && (rsp_idx == $past(rsp_idx) + 1'b1))

endmodule

@@ dv/cubic_bezier_subdivide_checker.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_subdivide_checker
// Watches both streams of the subdivision unit, predicts every point of each
// accepted curve with exact fixed-point de Casteljau lerps, and compares the
// returned points in order, field by field.
// ----------------------------------------------------------------------------
module cubic_bezier_subdivide_checker #(
   parameter int CW    = 32,
   parameter int TF    = 16,
   parameter int REQ_W = 296,
   parameter int RSP_W = 72
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             rsp_tlast,
   output int               mismatches,
   output int               pending,
   output int               curves_seen,
   output int               points_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import cbs_pkg::*;

   localparam longint PARAM_ONE   = longint'(1) << TF;
   localparam int     MAX_PRINTED = 30;

   typedef struct {
      longint x;
      longint y;
   } pt_t;

   typedef struct {
      logic [CW-1:0]    x;
      logic [CW-1:0]    y;
      logic [IDX_W-1:0] idx;
      logic             last;
   } point_t;

   point_t expected_points[$];
   int     error_count;
   int     curve_count;
   int     point_count;

   assign mismatches  = error_count;
   assign curves_seen = curve_count;
   assign points_seen = point_count;

   function automatic longint clamp_param(logic [TF:0] raw);
      longint v;
      v = longint'(raw);
      return (v > PARAM_ONE) ? PARAM_ONE : v;
   endfunction

   // a + floor((b - a) * t / 2^TF), exact in 64 bits
   function automatic pt_t lerp_pt(pt_t a, pt_t b, longint t);
      pt_t r;
      r.x = a.x + (((b.x - a.x) * t) >>> TF);
      r.y = a.y + (((b.y - a.y) * t) >>> TF);
      return r;
   endfunction

   function automatic void subdivide_curve(logic [REQ_W-1:0] data, cmd_type cmd);
      pt_t    cp[4];
      pt_t    sp[2][7];
      pt_t    res[NUM_PTS];
      longint tv[2];
      pt_t    ab, bc, cd, abc, bcd;
      int     n;
      point_t e;
      for (int i = 0; i < 4; i++) begin
         cp[i].x = longint'($signed(data[2*CW*i +: CW]));
         cp[i].y = longint'($signed(data[2*CW*i+CW +: CW]));
      end
      tv[0] = clamp_param(data[8*CW +: TF+1]);
      tv[1] = clamp_param(data[8*CW+TF+1 +: TF+1]);
      for (int k = 0; k < 2; k++) begin
         ab  = lerp_pt(cp[0], cp[1], tv[k]);
         bc  = lerp_pt(cp[1], cp[2], tv[k]);
         cd  = lerp_pt(cp[2], cp[3], tv[k]);
         abc = lerp_pt(ab, bc, tv[k]);
         bcd = lerp_pt(bc, cd, tv[k]);
         sp[k][0] = cp[0];
         sp[k][1] = ab;
         sp[k][2] = abc;
         sp[k][3] = lerp_pt(abc, bcd, tv[k]);
         sp[k][4] = bcd;
         sp[k][5] = cd;
         sp[k][6] = cp[3];
      end
      if (cmd == CMD_SINGLE) begin
         for (int i = 0; i < 7; i++) res[i] = sp[0][i];
         n = 7;
      end else begin
         for (int i = 0; i < 4; i++) res[i] = sp[0][i];
         res[4] = lerp_pt(sp[0][2], sp[0][4], tv[1]);
         res[5] = lerp_pt(sp[1][2], sp[1][4], tv[0]);
         for (int i = 0; i < 4; i++) res[6+i] = sp[1][3+i];
         n = 10;
      end
      for (int i = 0; i < n; i++) begin
         e.x    = CW'(res[i].x);
         e.y    = CW'(res[i].y);
         e.idx  = IDX_W'(i);
         e.last = (i == n - 1);
         expected_points = {expected_points, e};
      end
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("checker: %s mismatch on point %0d: got %0h, expected %0h",
                  field, point_count, got, want);
   endtask

   task automatic check_point();
      point_t got;
      point_t want;
      got.x    = rsp_tdata[CW-1:0];
      got.y    = rsp_tdata[2*CW-1:CW];
      got.idx  = rsp_tdata[2*CW +: IDX_W];
      got.last = rsp_tlast;
      if (expected_points.size() == 0) begin
         report_mismatch("unexpected point", got.x, 0);
      end else begin
         want = expected_points.pop_front();
         if (got.x !== want.x) report_mismatch("point_x", got.x, want.x);
         if (got.y !== want.y) report_mismatch("point_y", got.y, want.y);
         if (got.idx !== want.idx) report_mismatch("point_index", got.idx, want.idx);
         if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      end
      point_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_point();
         if (req_tvalid && req_tready) begin
            subdivide_curve(req_tdata, cmd_type'(req_tuser));
            curve_count++;
         end
      end
      pending = expected_points.size();
   end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives curves into the cubic Bezier subdivision unit: a directed set of
// extreme coordinates and split parameters, a long output stall, random
// traffic with gaps on both sides, and a stretch at full rate.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cbs_pkg::*;

   localparam int CW    = 32;
   localparam int TF    = 16;
   localparam int REQ_W = ((8*CW + 2*(TF+1) + 7) / 8) * 8;
   localparam int RSP_W = ((2*CW + IDX_W + 7) / 8) * 8;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;

   localparam logic [CW-1:0] COORD_MIN = 32'h8000_0000;
   localparam logic [CW-1:0] COORD_MAX = 32'h7fff_ffff;
   localparam logic [TF:0]   T_ZERO    = 17'h00000;
   localparam logic [TF:0]   T_ONE     = 17'h10000;
   localparam logic [TF:0]   T_MAX     = 17'h1ffff;

   typedef enum logic [1:0] {
      TR_DIRECTED,
      TR_HOLD,
      TR_RANDOM,
      TR_QUIET
   } traffic_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   int          mismatches;
   int          pending;
   int          curves_seen;
   int          points_seen;
   int          cycle_count;
   int          hold_left;
   bit          hold_done;
   traffic_type traffic;

   cubic_bezier_subdivide_unit #(
      .COORD_WIDTH(CW),
      .T_FRAC_BITS(TF)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   cubic_bezier_subdivide_checker #(
      .CW   (CW),
      .TF   (TF),
      .REQ_W(REQ_W),
      .RSP_W(RSP_W)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .pending    (pending),
      .curves_seen(curves_seen),
      .points_seen(points_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d points outstanding", cycle_count, pending);
         $display("testbench: errors");
         $finish;
      end
   end

   // result side: one long hold-off, random stalls, none in the quiet stretch
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && traffic == TR_HOLD) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (traffic == TR_QUIET) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 12);
         end
      end
   end

   function automatic logic [CW-1:0] pick_coord(bit extreme);
      if (extreme && $urandom_range(3) != 0) begin
         case ($urandom_range(4))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return '1;
            default: return 32'd1;
         endcase
      end
      if ($urandom_range(3) == 0) return $urandom_range(4095) - 32'd2048;
      return $urandom();
   endfunction

   function automatic logic [TF:0] pick_param();
      case ($urandom_range(11))
         0: return T_ZERO;
         1: return T_ONE;
         2: return T_ONE - 17'd1;
         3: return 17'd1;
         4: return (TF+1)'($urandom_range(int'(T_MAX), int'(T_ONE) + 1));
         default: return (TF+1)'($urandom_range(int'(T_ONE)));
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] pack_curve(bit extreme, logic [TF:0] t0,
                                                   logic [TF:0] t1);
      logic [REQ_W-1:0] d;
      d = '0;
      for (int i = 0; i < 8; i++) d[CW*i +: CW] = pick_coord(extreme);
      d[8*CW +: TF+1]      = t0;
      d[8*CW+TF+1 +: TF+1] = t1;
      return d;
   endfunction

   task automatic send_curve(cmd_type cmd, logic [REQ_W-1:0] data);
      @(negedge clock);
      if ((traffic == TR_DIRECTED || traffic == TR_RANDOM) && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_curve();
      logic [TF:0] t0;
      logic [TF:0] t1;
      logic [TF:0] tmp;
      t0 = pick_param();
      t1 = pick_param();
      if (t1 < t0 && $urandom_range(9) < 7) begin
         tmp = t0;
         t0  = t1;
         t1  = tmp;
      end
      send_curve(cmd_type'($urandom_range(1)), pack_curve($urandom_range(3) == 0, t0, t1));
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_SINGLE;
      traffic    = TR_DIRECTED;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_curve(CMD_SINGLE, pack_curve(1'b1, T_ZERO, T_ZERO));
      send_curve(CMD_SINGLE, pack_curve(1'b1, T_ONE, T_ZERO));
      send_curve(CMD_SINGLE, pack_curve(1'b1, T_MAX, T_MAX));
      send_curve(CMD_SINGLE, pack_curve(1'b1, 17'h08000, T_ONE));
      send_curve(CMD_SINGLE, pack_curve(1'b1, 17'd1, T_ZERO));
      send_curve(CMD_SINGLE, pack_curve(1'b1, T_ONE - 17'd1, T_MAX));
      send_curve(CMD_SINGLE, pack_curve(1'b1, T_ONE + 17'd1, 17'h0ffff));
      send_curve(CMD_SINGLE, pack_curve(1'b0, 17'h15555, 17'h0aaaa));
      send_curve(CMD_DOUBLE, pack_curve(1'b1, T_ZERO, T_ONE));
      send_curve(CMD_DOUBLE, pack_curve(1'b1, 17'h04000, 17'h0c000));
      send_curve(CMD_DOUBLE, pack_curve(1'b1, 17'h0c000, 17'h04000));
      send_curve(CMD_DOUBLE, pack_curve(1'b1, T_ONE, T_ONE));
      send_curve(CMD_DOUBLE, pack_curve(1'b1, T_ZERO, T_ZERO));
      send_curve(CMD_DOUBLE, pack_curve(1'b1, T_MAX, 17'h11170));
      send_curve(CMD_DOUBLE, pack_curve(1'b1, 17'd1, T_ONE - 17'd1));
      send_curve(CMD_DOUBLE, pack_curve(1'b1, T_ONE, T_ZERO));
      send_curve(CMD_DOUBLE, pack_curve(1'b0, 17'h0aaaa, 17'h15555));
      send_curve(CMD_DOUBLE, pack_curve(1'b0, 17'h05555, T_MAX));
      pause_until_drained();

      // output held off while curves keep coming: queue fills, input stalls
      traffic = TR_HOLD;
      repeat (25) send_random_curve();
      pause_until_drained();

      traffic = TR_RANDOM;
      repeat (330) send_random_curve();

      traffic = TR_QUIET;
      repeat (100) send_random_curve();

      pause_until_drained();
      repeat (40) @(posedge clock);

      $display("run covered %0d curves, single and double splits, t at 0, 1.0, saturated",
               curves_seen);
      $display("and out of order, under stalls on both sides; %0d points compared",
               points_seen);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cbs_pkg.sv
hdl/cbs_front.sv
hdl/cbs_queue.sv
hdl/cbs_lerp.sv
hdl/cbs_engine.sv
hdl/cbs_emit.sv
hdl/cubic_bezier_subdivide_unit.sv
dv/cubic_bezier_subdivide_checker.sv
dv/testbench.sv
